// File: sv/sle_pkg.sv
package sle_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PUT
  } state_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
  } rsp_t;

endpackage

// File: sv/sorted_list_engine.sv
// Sorted store of up to DEPTH signed keys in one synchronous RAM, ascending,
// duplicates kept in arrival order. One item is worked at a time; each
// entry visited takes a RAM read step, then a compare and write-back step.
// Insert walks down from the top entry shifting larger keys up by one, then
// places the new key; into an empty store it goes straight to placing, and
// when full it is refused without visiting any entry. Remove and lookup
// walk up from entry 0: lookup stops at the first match or the last entry;
// remove always walks the whole list, shifting the tail down after the
// match. Remove or lookup on an empty store, or an unused op code, answers
// without visiting any entry. The result sits in an output register, so the
// next item is taken while the previous result waits.
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t                       state, state_next;
  op_t                          op_q, op_q_next;
  logic signed [DATA_WIDTH-1:0] key, key_next;
  logic [CNT_W-1:0]             cnt, cnt_next;
  logic [IDX_W-1:0]             idx, idx_next;
  logic [IDX_W-1:0]             wpos, wpos_next;
  logic                         found, found_next;
  logic                         res_pend, res_pend_next;
  logic                         res_ok, res_ok_next;
  logic                         rsp_valid_next;
  rsp_t                         rsp_next;

  // key store
  logic signed [DATA_WIDTH-1:0] mem [DEPTH];
  logic signed [DATA_WIDTH-1:0] rdata;
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic signed [DATA_WIDTH-1:0] wdata;

  logic             last;
  logic [CNT_W-1:0] top;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  assign top       = cnt - CNT_W'(1);
  assign last      = ({{(CNT_W-IDX_W){1'b0}}, idx} == top);
  assign req_stall = (state != S_IDLE) || res_pend;

  // next state and datapath control
  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    key_next       = key;
    cnt_next       = cnt;
    idx_next       = idx;
    wpos_next      = wpos;
    found_next     = found;
    res_pend_next  = res_pend;
    res_ok_next    = res_ok;
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    we             = 1'b0;
    waddr          = wpos;
    wdata          = key;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          op_q_next  = req.op;
          key_next   = req.value;
          found_next = 1'b0;
          unique case (req.op) inside
            OP_INSERT: begin
              if (cnt == CNT_W'(DEPTH)) begin
                res_pend_next = 1'b1;
                res_ok_next   = 1'b0;
              end else if (cnt == '0) begin
                wpos_next  = '0;
                state_next = S_PUT;
              end else begin
                idx_next   = top[IDX_W-1:0];
                state_next = S_READ;
              end
            end
            OP_REMOVE, OP_LOOKUP: begin
              if (cnt == '0) begin
                res_pend_next = 1'b1;
                res_ok_next   = 1'b0;
              end else begin
                idx_next   = '0;
                state_next = S_READ;
              end
            end
            default: begin
              res_pend_next = 1'b1;
              res_ok_next   = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        case (op_q)
          OP_INSERT: begin
            if (rdata > key) begin
              // shift larger key up one slot
              we    = 1'b1;
              waddr = idx + IDX_W'(1);
              wdata = rdata;
              if (idx == '0) begin
                wpos_next  = '0;
                state_next = S_PUT;
              end else begin
                idx_next   = idx - IDX_W'(1);
                state_next = S_READ;
              end
            end else begin
              wpos_next  = idx + IDX_W'(1);
              state_next = S_PUT;
            end
          end
          OP_REMOVE: begin
            // after the match, every key moves down one slot
            if (found) begin
              we    = 1'b1;
              waddr = idx - IDX_W'(1);
              wdata = rdata;
            end
            if (last) begin
              res_pend_next = 1'b1;
              res_ok_next   = found || (rdata == key);
              if (found || (rdata == key)) begin
                cnt_next = cnt - CNT_W'(1);
              end
              state_next = S_IDLE;
            end else begin
              found_next = found || (rdata == key);
              idx_next   = idx + IDX_W'(1);
              state_next = S_READ;
            end
          end
          default: begin
            if ((rdata == key) || last) begin
              res_pend_next = 1'b1;
              res_ok_next   = (rdata == key);
              state_next    = S_IDLE;
            end else begin
              idx_next   = idx + IDX_W'(1);
              state_next = S_READ;
            end
          end
        endcase
      end
      S_PUT: begin
        we            = 1'b1;
        waddr         = wpos;
        wdata         = key;
        cnt_next      = cnt + CNT_W'(1);
        res_pend_next = 1'b1;
        res_ok_next   = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // move a finished result into the output register once it is free
    if (res_pend && (!rsp_valid || !rsp_stall)) begin
      res_pend_next  = 1'b0;
      rsp_valid_next = 1'b1;
      rsp_next.ok    = res_ok;
      rsp_next.count = cnt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_pend  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      res_pend  <= res_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_q   <= op_q_next;
    key    <= key_next;
    idx    <= idx_next;
    wpos   <= wpos_next;
    found  <= found_next;
    res_ok <= res_ok_next;
    rsp    <= rsp_next;
  end

  // store never holds more than DEPTH keys
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("element count above depth");

  // count moves only on a completed insert or remove
  a_cnt_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(cnt) |-> ($past(state) == S_PUT) ||
                      (($past(state) == S_EVAL) && ($past(op_q) == OP_REMOVE)))
    else $error("element count changed outside an update");

  // RAM is written only in the compare or place steps
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_EVAL) || (state == S_PUT))
    else $error("key store written while not working");

  // a pending result is never dropped while waiting for the output
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    res_pend && rsp_valid && rsp_stall |=> res_pend)
    else $error("pending result lost");

endmodule
